@@ rtl/battery_charge_gauge_with_hysteresis_core_defines.svh @@
// ============================================================================
// Assertion macros for the battery charge gauge
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ============================================================================
`ifndef BATTERY_CHARGE_GAUGE_WITH_HYSTERESIS_CORE_DEFINES_SVH
`define BATTERY_CHARGE_GAUGE_WITH_HYSTERESIS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BCG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gauge check failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BCG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gauge check failed");
`else
`define BCG_ASSERT_NOW(label, ante, cons)
`define BCG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/bcg_pkg.sv @@
// ============================================================================
// bcg_pkg
// Shared types, constants and the voltage-to-charge map of the gauge.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bcg_pkg;

   localparam int SAMPLE_W          = 13;
   localparam int PERCENT_W         = 8;
   localparam int CHARGE_W          = 7;
   localparam int MARGIN_W          = 4;
   localparam int REQ_DATA_W        = 16;
   localparam int RSP_DATA_W        = 40;
   localparam int RSP_PAD_W         = RSP_DATA_W - (PERCENT_W + 2 * SAMPLE_W);
   localparam int BURST_LEN_DEFAULT = 6;
   localparam int LONG_AVG_DEFAULT  = 20;

   localparam logic [MARGIN_W-1:0]  MARGIN_RESET = 4'd5;
   localparam logic [PERCENT_W-1:0] NO_READING   = 8'd188;
   localparam logic [PERCENT_W-1:0] FULL_PERCENT = 8'd100;

   // Breakpoints of the discharge curve, in millivolts.
   localparam logic [SAMPLE_W-1:0] V_FULL        = 13'd4100;
   localparam logic [SAMPLE_W-1:0] V_KNEE        = 13'd3960;
   localparam logic [SAMPLE_W-1:0] V_LINEAR      = 13'd3220;
   localparam logic [SAMPLE_W-1:0] V_LOW         = 13'd3020;
   localparam logic [SAMPLE_W-1:0] KNEE_OFFSET   = 13'd3340;
   localparam logic [SAMPLE_W-1:0] LINEAR_OFFSET = 13'd3150;

   localparam logic [CHARGE_W-1:0] CHARGE_FULL  = 7'd100;
   localparam logic [CHARGE_W-1:0] CHARGE_LOW   = 7'd5;
   localparam logic [CHARGE_W-1:0] CHARGE_EMPTY = 7'd1;

   // 100/1043 as ceil(100 * 2^21 / 1043); exact for offsets below 1024.
   localparam logic [17:0] SLOPE_RECIP = 18'd201070;
   localparam int          SLOPE_SHIFT = 21;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_mv;
      logic                start_burst;
      logic [CHARGE_W-1:0] charge;
   } item_type;

   typedef struct packed {
      logic [PERCENT_W-1:0] shown_percent;
      logic [SAMPLE_W-1:0]  average_mv;
      logic                 window_closed;
   } window_result_type;

   function automatic logic [CHARGE_W-1:0] charge_percent(input logic [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] knee_diff;
      logic [SAMPLE_W-1:0] lin_diff;
      logic [27:0]         product;
      logic [CHARGE_W-1:0] result;
      knee_diff = v - KNEE_OFFSET;
      lin_diff  = v - LINEAR_OFFSET;
      product   = {18'd0, lin_diff[9:0]} * {10'd0, SLOPE_RECIP};
      if (v >= V_FULL) begin
         result = CHARGE_FULL;
      end else if (v >= V_KNEE) begin
         result = knee_diff[9:3];
      end else if (v >= V_LINEAR) begin
         result = product[SLOPE_SHIFT +: CHARGE_W];
      end else if (v >= V_LOW) begin
         result = CHARGE_LOW;
      end else begin
         result = CHARGE_EMPTY;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bcg_window.sv @@
// ============================================================================
// bcg_window
// Window accumulation, window means and the hysteresis display update.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "battery_charge_gauge_with_hysteresis_core_defines.svh"

module bcg_window #(
   parameter int BURST_LEN = bcg_pkg::BURST_LEN_DEFAULT,
   parameter int LONG_AVG  = bcg_pkg::LONG_AVG_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire bcg_pkg::item_type             item,
   input  wire logic [bcg_pkg::MARGIN_W-1:0]  margin,
   output bcg_pkg::window_result_type         result
);
   import bcg_pkg::*;

   typedef enum logic [1:0] {
      PH_LONG     = 2'd0,
      PH_POWER_ON = 2'd1,
      PH_BURST    = 2'd2
   } phase_type;

   localparam int POWER_ON_LEN = 2;
   localparam int MAX_WIN   = (BURST_LEN - 1 > LONG_AVG) ? BURST_LEN - 1 : LONG_AVG;
   localparam int MAX_COUNT = ((BURST_LEN > LONG_AVG) ? BURST_LEN : LONG_AVG) + 2;
   localparam int CNT_W     = $clog2(MAX_COUNT + 1);
   localparam int PSUM_W    = $clog2(100 * MAX_WIN + 1);
   localparam int VSUM_W    = $clog2(((1 << SAMPLE_W) - 1) * MAX_WIN + 1);
   localparam int DIV_W     = $clog2(MAX_WIN);
   localparam int PS        = PSUM_W + DIV_W;
   localparam int VS        = VSUM_W + DIV_W;

   // Reciprocals ceil(2^S / D); exact for every sum that fits its register.
   localparam logic [PS:0] P_RECIP_BURST =
      (PS + 1)'(((64'd1 << PS) + BURST_LEN - 2) / (BURST_LEN - 1));
   localparam logic [PS:0] P_RECIP_LONG =
      (PS + 1)'(((64'd1 << PS) + LONG_AVG - 1) / LONG_AVG);
   localparam logic [VS:0] V_RECIP_BURST =
      (VS + 1)'(((64'd1 << VS) + BURST_LEN - 2) / (BURST_LEN - 1));
   localparam logic [VS:0] V_RECIP_LONG =
      (VS + 1)'(((64'd1 << VS) + LONG_AVG - 1) / LONG_AVG);

   phase_type             phase_ff, phase_in, phase_base;
   logic [CNT_W-1:0]      count_ff, count_in, count_base, count_inc;
   logic [PSUM_W-1:0]     psum_ff, psum_in;
   logic [VSUM_W-1:0]     vsum_ff, vsum_in;
   logic [PERCENT_W-1:0]  display_ff, display_in;
   logic [SAMPLE_W-1:0]   average_ff, average_in;
   logic                  closed;

   logic [PS:0]           p_recip;
   logic [VS:0]           v_recip;
   logic [PSUM_W+PS:0]    p_prod;
   logic [VSUM_W+VS:0]    v_prod;
   logic [PERCENT_W-1:0]  p_mean;
   logic [SAMPLE_W-1:0]   v_mean;
   logic [PERCENT_W-1:0]  rise_gap, fall_gap, margin_ext;
   logic                  rise, fall, burst_take, long_take;

   always_comb begin
      phase_base = item.start_burst ? PH_BURST : phase_ff;
      count_base = item.start_burst ? '0 : count_ff;
      count_inc  = count_base + 1'b1;

      // Mean of the window held in the sums, for the window kind now active.
      p_recip = (phase_base == PH_BURST) ? P_RECIP_BURST : P_RECIP_LONG;
      v_recip = (phase_base == PH_BURST) ? V_RECIP_BURST : V_RECIP_LONG;
      p_prod  = {{(PS + 1){1'b0}}, psum_ff} * {{PSUM_W{1'b0}}, p_recip};
      v_prod  = {{(VS + 1){1'b0}}, vsum_ff} * {{VSUM_W{1'b0}}, v_recip};
      p_mean  = p_prod[PS +: PERCENT_W];
      v_mean  = v_prod[VS +: SAMPLE_W];

      rise       = p_mean > display_ff;
      fall       = p_mean < display_ff;
      rise_gap   = p_mean - display_ff;
      fall_gap   = display_ff - p_mean;
      margin_ext = {{(PERCENT_W - MARGIN_W){1'b0}}, margin};
      burst_take = rise || (display_ff > FULL_PERCENT) || (fall && (fall_gap > margin_ext));
      long_take  = (rise && (rise_gap > margin_ext)) || fall;

      closed     = 1'b0;
      phase_in   = phase_base;
      count_in   = count_inc;
      display_in = display_ff;
      average_in = average_ff;

      unique case (phase_base)
         PH_POWER_ON: begin
            if (count_inc > CNT_W'(POWER_ON_LEN)) begin
               closed     = 1'b1;
               display_in = psum_ff[PERCENT_W-1:0];
               average_in = vsum_ff[SAMPLE_W-1:0];
            end
         end
         PH_BURST: begin
            if (count_inc > CNT_W'(BURST_LEN)) begin
               closed = 1'b1;
               if (burst_take) begin
                  display_in = p_mean;
                  average_in = v_mean;
               end
            end
         end
         default: begin
            if (count_inc > CNT_W'(LONG_AVG + 1)) begin
               closed = 1'b1;
               if (long_take) begin
                  display_in = p_mean;
                  average_in = v_mean;
               end
            end
         end
      endcase

      if (closed) begin
         phase_in = PH_LONG;
         count_in = '0;
      end

      // The first sample of a window only clears the sums.
      psum_in = psum_ff;
      vsum_in = vsum_ff;
      if (!closed) begin
         if (count_inc == CNT_W'(1)) begin
            psum_in = '0;
            vsum_in = '0;
         end else begin
            psum_in = psum_ff + PSUM_W'(item.charge);
            vsum_in = vsum_ff + VSUM_W'(item.sample_mv);
         end
      end

      result.shown_percent = display_in;
      result.average_mv    = average_in;
      result.window_closed = closed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_POWER_ON;
         count_ff   <= '0;
         psum_ff    <= '0;
         vsum_ff    <= '0;
         display_ff <= NO_READING;
         average_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         psum_ff    <= psum_in;
         vsum_ff    <= vsum_in;
         display_ff <= display_in;
         average_ff <= average_in;
      end
   end

   `BCG_ASSERT_NEXT(a_close_restarts, step && closed, (count_ff == '0) && (phase_ff == PH_LONG))
   `BCG_ASSERT_NEXT(a_display_holds_open, step && !closed, $stable(display_ff) && $stable(average_ff))
   `BCG_ASSERT_NOW(a_display_range, 1'b1, (display_ff <= FULL_PERCENT) || (display_ff == NO_READING))
   `BCG_ASSERT_NOW(a_psum_bound, 1'b1, psum_ff <= PSUM_W'(100 * MAX_WIN))

endmodule

`default_nettype wire

@@ rtl/battery_charge_gauge_with_hysteresis_core.sv @@
// ============================================================================
// battery_charge_gauge_with_hysteresis_core
// Battery voltage samples in, windowed charge percent with hysteresis out.
// ============================================================================
//
//   Channel  Direction  Ports                        Contents
//   req      in         req_tvalid/tready/tdata/tuser sample_mv, start_burst
//   rsp      out        rsp_tvalid/tready/tdata/tlast shown_percent, average_mv,
//                                                     echo_mv, window_closed
//   csr      in         csr_wr_en/csr_wr_data         hysteresis_margin
//
// A sample can be taken in every cycle while the result register is free. Its
// result is offered on rsp once it has passed the input register and then the
// result register. The sample is mapped to a charge percent on its way into
// the input register; the window update, whose depth is set by the window-mean
// multipliers and the hysteresis compares that follow, sits between the two.
// Reset is synchronous: the display reads 188 (no reading yet), the power-on
// window is armed and the margin returns to 5.
// While rsp_tready is low the result holds, and one more sample can still be
// taken into the input register before req_tready drops.
//
`timescale 1ns / 1ps
`default_nettype none

module battery_charge_gauge_with_hysteresis_core #(
   parameter int BURST_LEN = bcg_pkg::BURST_LEN_DEFAULT,
   parameter int LONG_AVG  = bcg_pkg::LONG_AVG_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Configuration: hysteresis_margin.
   input  wire logic                             csr_wr_en,
   input  wire logic [bcg_pkg::MARGIN_W-1:0]     csr_wr_data,
   // Sample stream.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [bcg_pkg::REQ_DATA_W-1:0]   req_tdata,  // [12:0] sample_mv, rest zero
   input  wire logic                             req_tuser,  // [0] start_burst
   // Result stream.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [bcg_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // [7:0] shown_percent,
                                                             // [20:8] average_mv,
                                                             // [33:21] echo_mv, rest zero
   output logic                                  rsp_tlast   // window_closed
);
   import bcg_pkg::*;

   logic [MARGIN_W-1:0] margin_ff;

   // Input register: the sample, its burst flag and its charge percent.
   logic                stage_valid_ff, stage_valid_in;
   item_type            stage_ff;
   logic                req_take;
   logic                advance;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   window_result_type   rsp_result_ff;
   logic [SAMPLE_W-1:0] rsp_echo_ff;

   window_result_type   window_result;

   // The result register is free when it is empty or is being read out now.
   // The input register moves forward whenever the result register is free.
   assign advance        = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready     = !stage_valid_ff || advance;
   assign req_take       = req_tvalid && req_tready;
   assign stage_valid_in = req_take || (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else if (csr_wr_en) begin
         margin_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff.sample_mv   <= req_tdata[SAMPLE_W-1:0];
         stage_ff.start_burst <= req_tuser;
         stage_ff.charge      <= charge_percent(req_tdata[SAMPLE_W-1:0]);
      end
      if (advance) begin
         rsp_result_ff <= window_result;
         rsp_echo_ff   <= stage_ff.sample_mv;
      end
   end

   // Window state advances exactly once for each sample that moves into the
   // result register, so the order of results follows the order of transfers.
   bcg_window #(
      .BURST_LEN (BURST_LEN),
      .LONG_AVG  (LONG_AVG)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (stage_ff),
      .margin (margin_ff),
      .result (window_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_echo_ff, rsp_result_ff.average_mv,
                        rsp_result_ff.shown_percent};
   assign rsp_tlast  = rsp_result_ff.window_closed;

endmodule

`default_nettype wire
